>>> rtl/qsrf_pkg.sv
// Shared constants, codes and types of the quantized sample record framer.
`timescale 1ns / 1ps
package qsrf_pkg;

    // Record geometry
    localparam int PAYLOAD_BYTES = 3;
    localparam int HDR_BYTES     = 6;
    localparam int REC_BYTES     = HDR_BYTES + PAYLOAD_BYTES;
    localparam int CODE_W        = 8 * PAYLOAD_BYTES;
    // One extra quotient bit is the rounding bit.
    localparam int QUO_W         = CODE_W + 1;
    localparam int DIV_STAGES    = QUO_W;
    localparam int CNT_W         = $clog2(REC_BYTES);

    // Queue between the divider and the byte serializer
    localparam int FIFO_AW       = 2;
    localparam int FIFO_DEPTH    = 1 << FIFO_AW;

    // Configuration register indexes
    localparam logic [0:0] REG_MIN_VALUE = 1'b0;
    localparam logic [0:0] REG_MAX_VALUE = 1'b1;

    localparam logic signed [31:0] MIN_RESET = 32'sd0;
    localparam logic signed [31:0] MAX_RESET = 32'sd28160000;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BELOW = 2'd1;
    localparam logic [1:0] ST_ABOVE = 2'd2;

    // Byte positions inside a record
    localparam logic [CNT_W-1:0] IDX_FLAG_HI = CNT_W'(0);
    localparam logic [CNT_W-1:0] IDX_FLAG_LO = CNT_W'(1);
    localparam logic [CNT_W-1:0] IDX_LENGTH  = CNT_W'(2);
    localparam logic [CNT_W-1:0] IDX_TS_HI   = CNT_W'(3);
    localparam logic [CNT_W-1:0] IDX_TS_MID  = CNT_W'(4);
    localparam logic [CNT_W-1:0] IDX_TS_LO   = CNT_W'(5);
    localparam logic [CNT_W-1:0] IDX_PAYLOAD = CNT_W'(HDR_BYTES);
    localparam logic [CNT_W-1:0] IDX_LAST    = CNT_W'(REC_BYTES - 1);

    localparam logic [7:0] LENGTH_BYTE = 8'(REC_BYTES);

    // Classified item leaving the front stage
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] flag;
        logic [23:0] ts;
        logic [31:0] rem;
        logic [31:0] range;
    } cls_t;

    // Item inside the divider pipeline
    typedef struct packed {
        logic [1:0]       status;
        logic [15:0]      flag;
        logic [23:0]      ts;
        logic [31:0]      rem;
        logic [31:0]      range;
        logic [QUO_W-1:0] quo;
    } div_t;

    // Finished record entry held in the queue
    typedef struct packed {
        logic [1:0]        status;
        logic [15:0]       flag;
        logic [23:0]       ts;
        logic [CODE_W-1:0] code;
    } rec_t;

endpackage

>>> rtl/quantized_sample_record_framer_core.sv
// Output: one output word per cycle while m_tready is high; an in-range item gives 9 record words,
// an out-of-range item a single word; the 25-stage divider pipeline accepts one item per cycle
// unless a finished record waits on a full queue.
// The word serializer sets the sustained rate; a 4-entry queue decouples it from the divider.
// Reset (rst_n low, asynchronous) empties the pipeline and queue, sets min_value to 0
// and max_value to 28160000.
`timescale 1ns / 1ps
module quantized_sample_record_framer_core
    import qsrf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port
    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // Input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // record_flag[15:0], time_stamp[39:16], sample[71:40]
    // Output words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // data_byte[7:0]
    output logic        m_tlast,
    output logic [2:0]  m_tuser    // byte_valid[0], status[2:1]
);

    logic signed [31:0] min_reg;
    logic signed [31:0] max_reg;

    logic adv;
    logic cls_valid;
    cls_t cls;
    logic div_valid;
    rec_t div_rec;
    logic fifo_full;
    logic fifo_empty;
    logic fifo_wr;
    logic fifo_pop;
    rec_t fifo_data;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= MIN_RESET;
            max_reg <= MAX_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_MIN_VALUE: min_reg <= cfg_data;
                REG_MAX_VALUE: max_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // The front pipeline moves unless a finished record waits on a full queue.
    assign adv      = !div_valid || !fifo_full;
    assign fifo_wr  = div_valid && !fifo_full;
    assign s_tready = adv;

    qsrf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s_tvalid),
        .flag      (s_tdata[15:0]),
        .ts        (s_tdata[39:16]),
        .sample    (s_tdata[71:40]),
        .min_value (min_reg),
        .max_value (max_reg),
        .cls_valid (cls_valid),
        .cls       (cls)
    );

    qsrf_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (cls_valid),
        .cls_in    (cls),
        .out_valid (div_valid),
        .rec_out   (div_rec)
    );

    qsrf_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fifo_wr),
        .wr_data (div_rec),
        .full    (fifo_full),
        .rd_en   (fifo_pop),
        .rd_data (fifo_data),
        .empty   (fifo_empty)
    );

    qsrf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .fifo_empty (fifo_empty),
        .fifo_data  (fifo_data),
        .fifo_pop   (fifo_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule

>>> rtl/qsrf_front.sv
// Input register stage: offsets the sample and classifies it against the range.
`timescale 1ns / 1ps
module qsrf_front
    import qsrf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               in_valid,
    input  logic [15:0]        flag,
    input  logic [23:0]        ts,
    input  logic signed [31:0] sample,
    input  logic signed [31:0] min_value,
    input  logic signed [31:0] max_value,
    output logic               cls_valid,
    output cls_t               cls
);

    logic               valid_reg;
    logic [15:0]        flag_reg;
    logic [23:0]        ts_reg;
    logic signed [32:0] offset_reg;
    logic signed [32:0] range_reg;
    logic signed [32:0] offset_next;
    logic signed [32:0] range_next;

    // Offset and range in 33 bits so neither difference can overflow.
    assign offset_next = 33'(sample) - 33'(min_value);
    assign range_next  = 33'(max_value) - 33'(min_value);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            flag_reg   <= flag;
            ts_reg     <= ts;
            offset_reg <= offset_next;
            range_reg  <= range_next;
        end
    end

    // An empty or zero-width range and an above-range sample both report as above maximum.
    always_comb
    begin
        cls.flag  = flag_reg;
        cls.ts    = ts_reg;
        cls.rem   = offset_reg[31:0];
        cls.range = range_reg[31:0];
        if (range_reg[32] || (range_reg == 33'sd0))
        begin
            cls.status = ST_ABOVE;
        end
        else if (offset_reg[32])
        begin
            cls.status = ST_BELOW;
        end
        else if (offset_reg > range_reg)
        begin
            cls.status = ST_ABOVE;
        end
        else
        begin
            cls.status = ST_OK;
        end
    end

    assign cls_valid = valid_reg;

endmodule

>>> rtl/qsrf_div.sv
// Pipelined restoring divider: one quotient bit per stage, then rounding and saturation.
`timescale 1ns / 1ps
module qsrf_div
    import qsrf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic adv,
    input  logic in_valid,
    input  cls_t cls_in,
    output logic out_valid,
    output rec_t rec_out
);

    logic v_reg  [DIV_STAGES];
    div_t st_reg [DIV_STAGES];
    div_t st_in  [DIV_STAGES];
    div_t st_nx  [DIV_STAGES];

    logic [CODE_W-1:0] code_raw;
    logic              rnd;
    div_t              last;

    // Stage zero starts from the classified item with an empty quotient.
    always_comb
    begin
        st_in[0].status = cls_in.status;
        st_in[0].flag   = cls_in.flag;
        st_in[0].ts     = cls_in.ts;
        st_in[0].rem    = cls_in.rem;
        st_in[0].range  = cls_in.range;
        st_in[0].quo    = '0;
    end

    genvar k;
    generate
        for (k = 1; k < DIV_STAGES; k++)
        begin : g_link
            assign st_in[k] = st_reg[k-1];
        end

        // One shift, compare and subtract step per stage.
        for (k = 0; k < DIV_STAGES; k++)
        begin : g_step
            logic [32:0] shifted;
            logic [32:0] diff;
            logic        ge;

            assign shifted = {st_in[k].rem, 1'b0};
            assign diff    = shifted - {1'b0, st_in[k].range};
            assign ge      = (shifted >= {1'b0, st_in[k].range});

            always_comb
            begin
                st_nx[k]     = st_in[k];
                st_nx[k].rem = ge ? diff[31:0] : shifted[31:0];
                st_nx[k].quo = {st_in[k].quo[QUO_W-2:0], ge};
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_STAGES; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i < DIV_STAGES; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < DIV_STAGES; i++)
            begin
                st_reg[i] <= st_nx[i];
            end
        end
    end

    // The last quotient bit is the rounding bit; a carry past full scale saturates.
    assign last     = st_reg[DIV_STAGES-1];
    assign code_raw = last.quo[QUO_W-1:1];
    assign rnd      = last.quo[0];

    always_comb
    begin
        rec_out.status = last.status;
        rec_out.flag   = last.flag;
        rec_out.ts     = last.ts;
        if (rnd && !(&code_raw))
        begin
            rec_out.code = code_raw + CODE_W'(1);
        end
        else
        begin
            rec_out.code = code_raw;
        end
    end

    assign out_valid = v_reg[DIV_STAGES-1];

endmodule

>>> rtl/qsrf_fifo.sv
// Short queue of finished records between the divider and the byte serializer.
`timescale 1ns / 1ps
module qsrf_fifo
    import qsrf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  rec_t wr_data,
    output logic full,
    input  logic rd_en,
    output rec_t rd_data,
    output logic empty
);

    rec_t               mem [FIFO_DEPTH];
    logic [FIFO_AW:0]   wr_ptr_reg;
    logic [FIFO_AW:0]   rd_ptr_reg;

    assign empty = (wr_ptr_reg == rd_ptr_reg);
    assign full  = (wr_ptr_reg[FIFO_AW] != rd_ptr_reg[FIFO_AW]) &&
                   (wr_ptr_reg[FIFO_AW-1:0] == rd_ptr_reg[FIFO_AW-1:0]);

    assign rd_data = mem[rd_ptr_reg[FIFO_AW-1:0]];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg[FIFO_AW-1:0]] <= wr_data;
        end
    end

    // Pointers carry one wrap bit to tell full from empty.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

>>> rtl/qsrf_back.sv
// Byte serializer: turns each queued record into output words, one word per cycle while m_tready allows.
`timescale 1ns / 1ps
module qsrf_back
    import qsrf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fifo_empty,
    input  rec_t       fifo_data,
    output logic       fifo_pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast,
    output logic [2:0] m_tuser
);

    rec_t             work_reg;
    logic             work_v_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    logic             out_last_reg;
    logic             out_bv_reg;
    logic [1:0]       out_status_reg;

    logic             out_free;
    logic             emit;
    logic             is_last;
    logic             ok;
    logic [CNT_W-1:0] pay_idx;
    logic [7:0]       byte_sel;
    logic [7:0]       byte_next;

    assign ok       = (work_reg.status == ST_OK);
    assign out_free = !out_valid_reg || m_tready;
    assign emit     = work_v_reg && out_free;
    assign is_last  = !ok || (cnt_reg == IDX_LAST);
    assign fifo_pop = !fifo_empty && (!work_v_reg || (emit && is_last));
    assign pay_idx  = cnt_reg - IDX_PAYLOAD;

    // Record byte for the current position, header first and code MSB first.
    always_comb
    begin
        byte_sel = '0;
        case (cnt_reg)
            IDX_FLAG_HI: byte_sel = work_reg.flag[15:8];
            IDX_FLAG_LO: byte_sel = work_reg.flag[7:0];
            IDX_LENGTH:  byte_sel = LENGTH_BYTE;
            IDX_TS_HI:   byte_sel = work_reg.ts[23:16];
            IDX_TS_MID:  byte_sel = work_reg.ts[15:8];
            IDX_TS_LO:   byte_sel = work_reg.ts[7:0];
            default:
            begin
                for (int i = 0; i < PAYLOAD_BYTES; i++)
                begin
                    if (pay_idx == CNT_W'(i))
                    begin
                        byte_sel = work_reg.code[8*(PAYLOAD_BYTES-1-i) +: 8];
                    end
                end
            end
        endcase
    end

    // An out-of-range item gives a single zero word carrying its status.
    assign byte_next = ok ? byte_sel : 8'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_v_reg    <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fifo_pop)
            begin
                work_v_reg <= 1'b1;
            end
            else if (emit && is_last)
            begin
                work_v_reg <= 1'b0;
            end

            if (emit)
            begin
                cnt_reg <= is_last ? '0 : cnt_reg + 1'b1;
            end

            if (out_free)
            begin
                out_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fifo_pop)
        begin
            work_reg <= fifo_data;
        end
        if (emit)
        begin
            out_byte_reg   <= byte_next;
            out_last_reg   <= is_last;
            out_bv_reg     <= ok;
            out_status_reg <= work_reg.status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {out_status_reg, out_bv_reg};

endmodule
